### rtl/core/lfr_pkg.sv
// Shared types and constants for the LRU frame replacer.
`default_nettype none

package lfr_pkg;

   // Fixed field widths of the request and response items.
   localparam int CMD_W   = 2;
   localparam int FRAME_W = 6;
   localparam int COUNT_W = 7;

   // Number of frame numbers that the request field can name.
   localparam int FRAME_SPAN = 2 ** FRAME_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_PIN    = 2'd0,
      CMD_UNPIN  = 2'd1,
      CMD_VICTIM = 2'd2
   } cmd_type;

   // Controller to datapath strobes.
   typedef struct packed {
      logic load;     // capture the item and start the link reads
      logic commit;   // apply the update and load the result register
   } ctl_type;

endpackage

`default_nettype wire

### rtl/core/lfr_req_if.sv
// Request channel: one command with a frame number per item.
`default_nettype none

interface lfr_req_if;
   logic                        valid;
   logic                        ready;
   logic [lfr_pkg::CMD_W-1:0]   command;
   logic [lfr_pkg::FRAME_W-1:0] frame_number;

   modport source (output valid, output command, output frame_number, input ready);
   modport sink   (input valid, input command, input frame_number, output ready);
endinterface

`default_nettype wire

### rtl/core/lfr_rsp_if.sv
// Response channel: victim report and set size per item.
`default_nettype none

interface lfr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        victim_found;
   logic [lfr_pkg::FRAME_W-1:0] victim_frame;
   logic [lfr_pkg::COUNT_W-1:0] set_size;

   modport source (output valid, output victim_found, output victim_frame,
                   output set_size, input ready);
   modport sink   (input valid, input victim_found, input victim_frame,
                   input set_size, output ready);
endinterface

`default_nettype wire

### rtl/core/lru_frame_replacer_core.sv
// Top level of the LRU frame replacer: controller, datapath and channel hookup.
`default_nettype none

// The replacer keeps the evictable frames of a buffer pool in age order as a
// doubly linked list in two link memories, with one membership bit per frame.
// Each request item carries a command and a frame number: pin removes a
// present frame, unpin appends an absent frame at the newest end (a frame
// already present keeps its age), and victim removes and reports the oldest
// frame, or reports not found on an empty set. Command code 3 changes nothing,
// nor do pin and unpin of frame numbers at or above FRAME_COUNT. Each request
// gives exactly one response item with the set size after the command. An
// item first reads the frame's links from the link memories, then writes the
// relinked neighbors and loads the result register; only then is a new
// request taken, even while a result still waits on the response channel;
// the item after it holds in its update cycle until that result is taken.
// Membership bits clear at reset, so the block is ready once reset falls.

module lru_frame_replacer_core #(
   parameter int FRAME_COUNT = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lfr_req_if.sink    req_chan,
   lfr_rsp_if.source  rsp_chan
);

   lfr_pkg::ctl_type ctl;

   // Sequence each item: accept, read links, then commit.
   lfr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .ctl       (ctl)
   );

   // Hold the list state and drive the response payload.
   lfr_datapath #(
      .FRAME_COUNT (FRAME_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .req_command      (req_chan.command),
      .req_frame_number (req_chan.frame_number),
      .rsp_victim_found (rsp_chan.victim_found),
      .rsp_victim_frame (rsp_chan.victim_frame),
      .rsp_set_size     (rsp_chan.set_size)
   );

endmodule

`default_nettype wire

### rtl/core/lfr_datapath.sv
// Datapath: membership bits, link memories, list ends and result register.
`default_nettype none

module lfr_datapath #(
   parameter int FRAME_COUNT = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lfr_pkg::ctl_type            ctl,
   input  wire logic [lfr_pkg::CMD_W-1:0]   req_command,
   input  wire logic [lfr_pkg::FRAME_W-1:0] req_frame_number,
   output logic                             rsp_victim_found,
   output logic [lfr_pkg::FRAME_W-1:0]      rsp_victim_frame,
   output logic [lfr_pkg::COUNT_W-1:0]      rsp_set_size
);

   // Only frames the request field can name ever need storage.
   localparam int NumSlots = (FRAME_COUNT < lfr_pkg::FRAME_SPAN) ? FRAME_COUNT
                                                                  : lfr_pkg::FRAME_SPAN;
   localparam int SlotW = $clog2(NumSlots);

   logic [lfr_pkg::CMD_W-1:0]   cmd_ff;
   logic [lfr_pkg::FRAME_W-1:0] frame_ff;

   logic                        mark_ff [NumSlots];
   logic [SlotW-1:0]            oldest_ff, oldest_in;
   logic [SlotW-1:0]            newest_ff, newest_in;
   logic [lfr_pkg::COUNT_W-1:0] count_ff, count_in;

   logic [SlotW-1:0] next_mem [NumSlots];
   logic [SlotW-1:0] prev_mem [NumSlots];
   logic [SlotW-1:0] next_rd_ff, prev_rd_ff;
   logic [SlotW-1:0] rd_addr;

   logic             next_we, prev_we;
   logic [SlotW-1:0] next_wa, next_wd, prev_wa, prev_wd;

   logic             in_range, is_member, do_unlink, do_append, found;
   logic [SlotW-1:0] slot, target;

   logic                        found_ff;
   logic [lfr_pkg::FRAME_W-1:0] vframe_ff;
   logic [lfr_pkg::COUNT_W-1:0] size_ff;

   // Read the links of the frame this item touches.
   always_comb begin
      if (req_command == lfr_pkg::CMD_VICTIM) begin
         rd_addr = oldest_ff;
      end else begin
         rd_addr = req_frame_number[SlotW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= req_command;
         frame_ff <= req_frame_number;
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (ctl.load) begin
         next_rd_ff <= next_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (ctl.load) begin
         prev_rd_ff <= prev_mem[rd_addr];
      end
   end

   always_comb begin
      slot      = frame_ff[SlotW-1:0];
      in_range  = ({1'b0, frame_ff} < (lfr_pkg::FRAME_W + 1)'(NumSlots));
      is_member = in_range && mark_ff[slot];
      found     = (cmd_ff == lfr_pkg::CMD_VICTIM) && (count_ff != '0);
      do_unlink = ((cmd_ff == lfr_pkg::CMD_PIN) && is_member) || found;
      do_append = (cmd_ff == lfr_pkg::CMD_UNPIN) && in_range && !is_member;
      target    = found ? oldest_ff : slot;

      oldest_in = oldest_ff;
      newest_in = newest_ff;
      count_in  = count_ff;
      next_we   = 1'b0;
      next_wa   = newest_ff;
      next_wd   = slot;
      prev_we   = 1'b0;
      prev_wa   = slot;
      prev_wd   = newest_ff;

      if (do_unlink) begin
         count_in = count_ff - lfr_pkg::COUNT_W'(1);
         if (count_ff > lfr_pkg::COUNT_W'(1)) begin
            if (target == oldest_ff) begin
               oldest_in = next_rd_ff;
            end else if (target == newest_ff) begin
               newest_in = prev_rd_ff;
            end else begin
               // Bridge the neighbors around the removed node.
               next_we = ctl.commit;
               next_wa = prev_rd_ff;
               next_wd = next_rd_ff;
               prev_we = ctl.commit;
               prev_wa = next_rd_ff;
               prev_wd = prev_rd_ff;
            end
         end
      end else if (do_append) begin
         count_in  = count_ff + lfr_pkg::COUNT_W'(1);
         newest_in = slot;
         if (count_ff == '0) begin
            oldest_in = slot;
         end else begin
            next_we = ctl.commit;
            prev_we = ctl.commit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumSlots; i++) begin
            mark_ff[i] <= 1'b0;
         end
         oldest_ff <= '0;
         newest_ff <= '0;
         count_ff  <= '0;
      end else if (ctl.commit) begin
         if (do_unlink) begin
            mark_ff[target] <= 1'b0;
         end else if (do_append) begin
            mark_ff[slot] <= 1'b1;
         end
         oldest_ff <= oldest_in;
         newest_ff <= newest_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         found_ff  <= found;
         vframe_ff <= found ? lfr_pkg::FRAME_W'(oldest_ff) : '0;
         size_ff   <= count_in;
      end
   end

   assign rsp_victim_found = found_ff;
   assign rsp_victim_frame = vframe_ff;
   assign rsp_set_size     = size_ff;

endmodule

`default_nettype wire

### rtl/core/lfr_controller.sv
// Controller: sequences one item through the link read and the update.
`default_nettype none

module lfr_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output lfr_pkg::ctl_type      ctl
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      commit;

   // Finish only when the result register is free or being emptied.
   assign commit     = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = (state_ff == ST_IDLE);
   assign ctl.load   = req_valid && req_ready;
   assign ctl.commit = commit;
   assign rsp_valid  = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (commit) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire
